/* rtl/core/sliding_mode_temperature_controller_defines.svh */
// Assertion macros shared by the checker of the sliding mode temperature controller.
// Depends on nothing; the checker file includes it.
`ifndef SLIDING_MODE_TEMPERATURE_CONTROLLER_DEFINES_SVH
`define SLIDING_MODE_TEMPERATURE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SMTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/smtc_pkg.sv */
// Types and constants of the sliding mode temperature controller.
// Used by the divider, datapath, controller, top level and checker; depends on nothing.
package smtc_pkg;

   localparam int TEMP_W  = 16;
   localparam int ERR_W   = 17;
   localparam int DIFF_W  = 18;
   localparam int TIME_W  = 32;
   localparam int DRIVE_W = 16;
   localparam int CFG_W   = 16;
   localparam int THR_W   = 15;
   localparam int STAT_W  = 2;
   localparam int CHF_W   = 2;
   localparam int DT_W    = 10;
   localparam int PROD_W  = 28;
   localparam int DE_W    = 28;
   localparam int S_W     = 45;
   localparam int DIV_W   = 48;
   localparam int DVS_W   = 16;
   localparam int SAT_W   = 10;
   localparam int P1_W    = 32;
   localparam int P2_W    = 27;
   localparam int N_W     = 41;
   localparam int CNT_W   = 6;
   localparam int CIDX_W  = 3;
   localparam int REQ_W   = 72;
   localparam int RSP_W   = 24;

   localparam logic [DT_W-1:0]          DT_MAX     = 10'd1000;
   localparam logic [DT_W-1:0]          DT_DEFAULT = 10'd100;
   localparam logic signed [PROD_W-1:0] MS_PER_S   = 28'sd1000;
   localparam logic [DIV_W-1:0]         SAT_ONE    = 48'd256;

   localparam logic [CIDX_W-1:0] REG_ALPHA     = 3'd0;
   localparam logic [CIDX_W-1:0] REG_GAIN      = 3'd1;
   localparam logic [CIDX_W-1:0] REG_PHI       = 3'd2;
   localparam logic [CIDX_W-1:0] REG_LAM_HEAT  = 3'd3;
   localparam logic [CIDX_W-1:0] REG_LAM_COOL  = 3'd4;
   localparam logic [CIDX_W-1:0] REG_THRESHOLD = 3'd5;
   localparam logic [CIDX_W-1:0] REG_LIMIT     = 3'd6;

   localparam logic [CFG_W-1:0] RST_ALPHA     = 16'd3072;
   localparam logic [CFG_W-1:0] RST_GAIN      = 16'd2560;
   localparam logic [CFG_W-1:0] RST_PHI       = 16'd7680;
   localparam logic [CFG_W-1:0] RST_LAM_HEAT  = 16'd768;
   localparam logic [CFG_W-1:0] RST_LAM_COOL  = 16'd0;
   localparam logic [THR_W-1:0] RST_THRESHOLD = 15'd16;
   localparam logic [CFG_W-1:0] RST_LIMIT     = 16'd25600;

   typedef enum logic [STAT_W-1:0] {
      STATUS_NORMAL = 2'd0,
      STATUS_FIRST  = 2'd1,
      STATUS_COOL   = 2'd2
   } status_code_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_DE_MUL, S_DE_START, S_DE_WAIT, S_S_MUL, S_S_START,
      S_S_WAIT, S_N_MUL, S_N_SUM, S_U_START, S_U_WAIT, S_U_TAKE, S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_PREP, OP_DE_MUL, OP_DE_DIV, OP_S_MUL, OP_S_DIV,
      OP_N_MUL, OP_N_SUM, OP_U_DIV, OP_U_TAKE, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      div_start;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic cool;
      logic div_busy;
   } sts_type;

endpackage

/* rtl/core/smtc_div.sv */
// Restoring divider, one quotient bit per cycle, for the controller datapath.
// Depends on smtc_pkg.
module smtc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [smtc_pkg::DIV_W-1:0] dividend,
   input  logic [smtc_pkg::DVS_W-1:0] divisor,
   output logic                       busy,
   output logic [smtc_pkg::DIV_W-1:0] quotient
);

   logic [smtc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [smtc_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [smtc_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [smtc_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [smtc_pkg::DVS_W:0]   trial;

   always_comb begin
      trial  = {rem_ff, quo_ff[smtc_pkg::DIV_W-1]};
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = smtc_pkg::CNT_W'(smtc_pkg::DIV_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = smtc_pkg::DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[smtc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[smtc_pkg::DVS_W-1:0];
            quo_in = {quo_ff[smtc_pkg::DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

/* rtl/core/smtc_datapath.sv */
// Datapath of the sliding mode temperature controller: configuration, channel state,
// arithmetic steps and result register. Depends on smtc_pkg and smtc_div.
module smtc_datapath #(
   parameter int CHANNELS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smtc_pkg::cmd_type             cmd,
   output smtc_pkg::sts_type             sts,
   input  logic                          csr_valid,
   input  logic [smtc_pkg::CIDX_W-1:0]   csr_index,
   input  logic [smtc_pkg::CFG_W-1:0]    csr_data,
   input  logic [smtc_pkg::CHF_W-1:0]    in_channel,
   input  logic signed [smtc_pkg::TEMP_W-1:0] in_temperature,
   input  logic signed [smtc_pkg::TEMP_W-1:0] in_target,
   input  logic [smtc_pkg::TIME_W-1:0]   in_timestamp_ms,
   output logic [smtc_pkg::CHF_W-1:0]    out_channel,
   output logic [smtc_pkg::DRIVE_W-1:0]  drive,
   output logic [smtc_pkg::STAT_W-1:0]   status
);

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Configuration registers.
   logic [smtc_pkg::CFG_W-1:0] alpha_ff, gain_ff, phi_ff, lheat_ff, lcool_ff, limit_ff;
   logic [smtc_pkg::THR_W-1:0] thr_ff;

   // Channel state.
   logic                               started_ff [CHANNELS];
   logic [smtc_pkg::TIME_W-1:0]        ptime_ff   [CHANNELS];
   logic signed [smtc_pkg::ERR_W-1:0]  perr_ff    [CHANNELS];
   logic [smtc_pkg::DRIVE_W-1:0]       pdrive_ff  [CHANNELS];

   // Request and working registers.
   logic [smtc_pkg::CHF_W-1:0]         chf_ff;
   logic signed [smtc_pkg::TEMP_W-1:0] temp_ff, tgt_ff;
   logic [smtc_pkg::TIME_W-1:0]        now_ff;
   logic signed [smtc_pkg::DIFF_W-1:0] diff_ff;
   logic [smtc_pkg::DT_W-1:0]          dt_ff;
   logic signed [smtc_pkg::PROD_W-1:0] prod_ff;
   logic signed [smtc_pkg::DE_W-1:0]   de_ff;
   logic signed [smtc_pkg::S_W-1:0]    s_ff;
   logic [smtc_pkg::P1_W-1:0]          p1_ff;
   logic signed [smtc_pkg::P2_W-1:0]   p2_ff;
   logic signed [smtc_pkg::N_W-1:0]    n_ff;
   logic [smtc_pkg::DRIVE_W-1:0]       res_drive_ff;
   logic [smtc_pkg::STAT_W-1:0]        res_status_ff;
   logic [smtc_pkg::CHF_W-1:0]         rsp_chan_ff;
   logic [smtc_pkg::DRIVE_W-1:0]       rsp_drive_ff;
   logic [smtc_pkg::STAT_W-1:0]        rsp_status_ff;

   logic [IW-1:0]                      idx;
   logic signed [smtc_pkg::ERR_W-1:0]  err;
   logic [smtc_pkg::TIME_W-1:0]        d_raw;
   logic [smtc_pkg::DT_W-1:0]          d_sel;
   logic                               first, cool;
   logic [smtc_pkg::CFG_W-1:0]         alpha_eff, phi_eff, lam;
   logic signed [smtc_pkg::DE_W-1:0]   de_c;
   logic signed [smtc_pkg::S_W-1:0]    s_c;
   logic [smtc_pkg::PROD_W-1:0]        prod_mag;
   logic [smtc_pkg::S_W-1:0]           s_mag;
   logic [8:0]                         sat_mag;
   logic signed [smtc_pkg::SAT_W-1:0]  sat_c;
   logic [smtc_pkg::DRIVE_W-1:0]       u_c;
   logic [smtc_pkg::DIV_W-1:0]         dividend, quotient;
   logic [smtc_pkg::DVS_W-1:0]         divisor;
   logic                               div_busy;

   // Channel field folded onto the implemented channels.
   always_comb begin
      logic [4:0] red;
      red = 5'(chf_ff);
      for (int k = 0; k < 3; k++) begin
         if (red >= 5'(CHANNELS)) begin
            red = red - 5'(CHANNELS);
         end
      end
      idx = red[IW-1:0];
   end

   assign err   = smtc_pkg::ERR_W'(tgt_ff) - smtc_pkg::ERR_W'(temp_ff);
   assign d_raw = now_ff - ptime_ff[idx];
   assign d_sel = (d_raw == '0 || d_raw > smtc_pkg::TIME_W'(smtc_pkg::DT_MAX)) ?
                  smtc_pkg::DT_DEFAULT : d_raw[smtc_pkg::DT_W-1:0];
   assign first = !started_ff[idx];
   assign cool  = err < -$signed({2'b00, thr_ff});

   assign alpha_eff = (alpha_ff == '0) ? smtc_pkg::CFG_W'(1) : alpha_ff;
   assign phi_eff   = (phi_ff == '0) ? smtc_pkg::CFG_W'(1) : phi_ff;

   // Signed derivative from the magnitude quotient, truncated toward zero.
   assign prod_mag = prod_ff[smtc_pkg::PROD_W-1] ? smtc_pkg::PROD_W'(-prod_ff) : prod_ff;
   assign de_c = prod_ff[smtc_pkg::PROD_W-1] ? -$signed(quotient[smtc_pkg::DE_W-1:0]) :
                 $signed(quotient[smtc_pkg::DE_W-1:0]);
   assign lam  = (de_c > 0) ? lcool_ff : lheat_ff;
   assign s_c  = (smtc_pkg::S_W'(err) <<< 8) +
                 smtc_pkg::S_W'($signed({1'b0, lam}) * de_c);

   assign s_mag   = s_ff[smtc_pkg::S_W-1] ? smtc_pkg::S_W'(-s_ff) : s_ff;
   assign sat_mag = (quotient > smtc_pkg::SAT_ONE) ? 9'd256 : quotient[8:0];
   assign sat_c   = s_ff[smtc_pkg::S_W-1] ? -$signed({1'b0, sat_mag}) :
                    $signed({1'b0, sat_mag});

   assign u_c = n_ff[smtc_pkg::N_W-1] ? '0 :
                (quotient > smtc_pkg::DIV_W'(limit_ff)) ? limit_ff :
                quotient[smtc_pkg::DRIVE_W-1:0];

   always_comb begin
      case (cmd.op)
         smtc_pkg::OP_DE_DIV: begin
            dividend = smtc_pkg::DIV_W'(prod_mag);
            divisor  = smtc_pkg::DVS_W'(dt_ff);
         end
         smtc_pkg::OP_S_DIV: begin
            dividend = {s_mag[smtc_pkg::DIV_W-5:0], 4'b0000};
            divisor  = phi_eff;
         end
         default: begin
            dividend = smtc_pkg::DIV_W'(n_ff[smtc_pkg::N_W-2:0]);
            divisor  = alpha_eff;
         end
      endcase
   end

   smtc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= smtc_pkg::RST_ALPHA;
         gain_ff  <= smtc_pkg::RST_GAIN;
         phi_ff   <= smtc_pkg::RST_PHI;
         lheat_ff <= smtc_pkg::RST_LAM_HEAT;
         lcool_ff <= smtc_pkg::RST_LAM_COOL;
         thr_ff   <= smtc_pkg::RST_THRESHOLD;
         limit_ff <= smtc_pkg::RST_LIMIT;
      end else if (csr_valid) begin
         case (csr_index)
            smtc_pkg::REG_ALPHA:     alpha_ff <= csr_data;
            smtc_pkg::REG_GAIN:      gain_ff  <= csr_data;
            smtc_pkg::REG_PHI:       phi_ff   <= csr_data;
            smtc_pkg::REG_LAM_HEAT:  lheat_ff <= csr_data;
            smtc_pkg::REG_LAM_COOL:  lcool_ff <= csr_data;
            smtc_pkg::REG_THRESHOLD: thr_ff   <= csr_data[smtc_pkg::THR_W-1:0];
            smtc_pkg::REG_LIMIT:     limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            started_ff[i] <= 1'b0;
            ptime_ff[i]   <= '0;
            perr_ff[i]    <= '0;
            pdrive_ff[i]  <= '0;
         end
      end else if (cmd.op == smtc_pkg::OP_PREP) begin
         started_ff[idx] <= 1'b1;
         ptime_ff[idx]   <= now_ff;
         if (!first && cool) begin
            perr_ff[idx]   <= err;
            pdrive_ff[idx] <= '0;
         end
      end else if (cmd.op == smtc_pkg::OP_U_TAKE) begin
         perr_ff[idx]   <= err;
         pdrive_ff[idx] <= u_c;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         smtc_pkg::OP_LOAD: begin
            chf_ff  <= in_channel;
            temp_ff <= in_temperature;
            tgt_ff  <= in_target;
            now_ff  <= in_timestamp_ms;
         end
         smtc_pkg::OP_PREP: begin
            diff_ff       <= smtc_pkg::DIFF_W'(err) - smtc_pkg::DIFF_W'(perr_ff[idx]);
            dt_ff         <= d_sel;
            res_drive_ff  <= '0;
            res_status_ff <= first ? smtc_pkg::STATUS_FIRST : smtc_pkg::STATUS_COOL;
         end
         smtc_pkg::OP_DE_MUL: prod_ff <= smtc_pkg::PROD_W'(diff_ff) * smtc_pkg::MS_PER_S;
         smtc_pkg::OP_S_MUL: begin
            de_ff <= de_c;
            s_ff  <= s_c;
         end
         smtc_pkg::OP_N_MUL: begin
            p1_ff <= alpha_eff * pdrive_ff[idx];
            p2_ff <= smtc_pkg::P2_W'($signed({1'b0, gain_ff}) * sat_c);
         end
         smtc_pkg::OP_N_SUM: begin
            n_ff <= (smtc_pkg::N_W'(de_ff) <<< 12) + smtc_pkg::N_W'({1'b0, p1_ff}) +
                    smtc_pkg::N_W'(p2_ff);
         end
         smtc_pkg::OP_U_TAKE: begin
            res_drive_ff  <= u_c;
            res_status_ff <= smtc_pkg::STATUS_NORMAL;
         end
         smtc_pkg::OP_EMIT: begin
            rsp_chan_ff   <= chf_ff;
            rsp_drive_ff  <= res_drive_ff;
            rsp_status_ff <= res_status_ff;
         end
         default: ;
      endcase
   end

   assign sts.first    = first;
   assign sts.cool     = cool;
   assign sts.div_busy = div_busy;

   assign out_channel = rsp_chan_ff;
   assign drive       = rsp_drive_ff;
   assign status      = rsp_status_ff;

endmodule

/* rtl/core/smtc_ctrl.sv */
// Sequencing state machine of the sliding mode temperature controller.
// Depends on smtc_pkg; drives the datapath by command and reads its status.
module smtc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  smtc_pkg::sts_type sts,
   output smtc_pkg::cmd_type cmd
);

   smtc_pkg::state_type state_ff, state_in;
   logic                valid_ff, valid_in;
   logic                slot_free;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smtc_pkg::S_IDLE:     if (req_tvalid) state_in = smtc_pkg::S_PREP;
         smtc_pkg::S_PREP:     state_in = (sts.first || sts.cool) ? smtc_pkg::S_EMIT :
                                          smtc_pkg::S_DE_MUL;
         smtc_pkg::S_DE_MUL:   state_in = smtc_pkg::S_DE_START;
         smtc_pkg::S_DE_START: state_in = smtc_pkg::S_DE_WAIT;
         smtc_pkg::S_DE_WAIT:  if (!sts.div_busy) state_in = smtc_pkg::S_S_MUL;
         smtc_pkg::S_S_MUL:    state_in = smtc_pkg::S_S_START;
         smtc_pkg::S_S_START:  state_in = smtc_pkg::S_S_WAIT;
         smtc_pkg::S_S_WAIT:   if (!sts.div_busy) state_in = smtc_pkg::S_N_MUL;
         smtc_pkg::S_N_MUL:    state_in = smtc_pkg::S_N_SUM;
         smtc_pkg::S_N_SUM:    state_in = smtc_pkg::S_U_START;
         smtc_pkg::S_U_START:  state_in = smtc_pkg::S_U_WAIT;
         smtc_pkg::S_U_WAIT:   if (!sts.div_busy) state_in = smtc_pkg::S_U_TAKE;
         smtc_pkg::S_U_TAKE:   state_in = smtc_pkg::S_EMIT;
         smtc_pkg::S_EMIT:     if (slot_free) state_in = smtc_pkg::S_IDLE;
         default:              state_in = smtc_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op        = smtc_pkg::OP_NONE;
      cmd.div_start = 1'b0;
      req_tready    = 1'b0;
      valid_in      = valid_ff && !rsp_tready;
      case (state_ff)
         smtc_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = smtc_pkg::OP_LOAD;
         end
         smtc_pkg::S_PREP:     cmd.op = smtc_pkg::OP_PREP;
         smtc_pkg::S_DE_MUL:   cmd.op = smtc_pkg::OP_DE_MUL;
         smtc_pkg::S_DE_START: begin
            cmd.op        = smtc_pkg::OP_DE_DIV;
            cmd.div_start = 1'b1;
         end
         smtc_pkg::S_S_MUL:    if (!sts.div_busy) cmd.op = smtc_pkg::OP_S_MUL;
         smtc_pkg::S_S_START: begin
            cmd.op        = smtc_pkg::OP_S_DIV;
            cmd.div_start = 1'b1;
         end
         smtc_pkg::S_N_MUL:    cmd.op = smtc_pkg::OP_N_MUL;
         smtc_pkg::S_N_SUM:    cmd.op = smtc_pkg::OP_N_SUM;
         smtc_pkg::S_U_START: begin
            cmd.op        = smtc_pkg::OP_U_DIV;
            cmd.div_start = 1'b1;
         end
         smtc_pkg::S_U_TAKE:   cmd.op = smtc_pkg::OP_U_TAKE;
         smtc_pkg::S_EMIT: begin
            if (slot_free) begin
               cmd.op   = smtc_pkg::OP_EMIT;
               valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smtc_pkg::S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

/* rtl/core/sliding_mode_temperature_controller.sv */
// A first or forced-cooling request goes from its preparation step straight to emit; a controlled
// one takes three passes of the shared bit-serial divider (derivative, boundary layer
// saturation, drive). One request at a time: the next is accepted only after the previous one
// has reached the emit step and the controller is idle again, and a new one is taken
// while the previous result waits in the output register. Synchronous active-high reset
// restores the default gains and clears every channel's state at once.
module sliding_mode_temperature_controller #(
   parameter int CHANNELS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [1:0] channel, [17:2] temperature, [33:18] target, [65:34] timestamp_ms
   input  logic [smtc_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [1:0] out_channel, [17:2] drive, [19:18] status
   output logic [smtc_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [smtc_pkg::CIDX_W-1:0]   csr_index,
   input  logic [smtc_pkg::CFG_W-1:0]    csr_data
);

   smtc_pkg::cmd_type                 cmd;
   smtc_pkg::sts_type                 sts;
   logic [smtc_pkg::CHF_W-1:0]        out_channel;
   logic [smtc_pkg::DRIVE_W-1:0]      drive;
   logic [smtc_pkg::STAT_W-1:0]       status;

   assign csr_ready = 1'b1;

   smtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   smtc_datapath #(.CHANNELS(CHANNELS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .in_channel      (req_tdata[1:0]),
      .in_temperature  ($signed(req_tdata[17:2])),
      .in_target       ($signed(req_tdata[33:18])),
      .in_timestamp_ms (req_tdata[65:34]),
      .out_channel     (out_channel),
      .drive           (drive),
      .status          (status)
   );

   assign rsp_tdata = {4'b0000, status, drive, out_channel};

endmodule

/* rtl/core/smtc_checker.sv */
// Port-level checks of the sliding mode temperature controller, bound to the top level.
// Depends on smtc_pkg and sliding_mode_temperature_controller_defines.svh.
`include "sliding_mode_temperature_controller_defines.svh"

module smtc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [smtc_pkg::RSP_W-1:0] rsp_tdata
);

   `SMTC_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, rsp_tdata[19:18] == smtc_pkg::STATUS_NORMAL || rsp_tdata[19:18] == smtc_pkg::STATUS_FIRST || rsp_tdata[19:18] == smtc_pkg::STATUS_COOL, "unknown status code")
   `SMTC_ASSERT_NOW(a_idle_drive, clock, reset, rsp_tvalid && rsp_tdata[19:18] != smtc_pkg::STATUS_NORMAL, rsp_tdata[17:2] == 16'd0, "nonzero drive outside normal control")
   `SMTC_ASSERT_NOW(a_padding, clock, reset, rsp_tvalid, rsp_tdata[23:20] == 4'd0, "result padding not zero")
   `SMTC_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind sliding_mode_temperature_controller smtc_checker u_smtc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
